// ===== rtl/core/sgam_pkg.sv =====
`timescale 1ns / 1ps

package sgam_pkg;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int POS_W     = 10;
  localparam int SRC_W     = 2;
  localparam int GAIN_W    = 24;
  localparam int ACC_W     = 42;
  localparam int PROD_W    = 41;
  localparam int POS_EXT_W = 13;
  localparam int SRC_CMP_W = 4;

  // configuration space
  localparam int NUM_GAIN_REGS = 4;
  localparam int CFG_AW        = 4;
  localparam int CFG_DW        = 32;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

  // integer pcm range after truncation
  localparam int PCM_FLOOR_W = ACC_W - 16;

  typedef logic [GAIN_W-1:0] gain_t;
  typedef gain_t [NUM_GAIN_REGS-1:0] gain_bank_t;

  // accumulated sum handed to the output converter
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    logic [ACC_W-1:0] sum;
  } acc_beat_t;

endpackage

// ===== rtl/core/sgam_cfg_regs.sv =====
`timescale 1ns / 1ps

module sgam_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sgam_pkg::CFG_AW-1:0]       paddr,
  input  logic [sgam_pkg::CFG_DW-1:0]       pwdata,
  output logic [sgam_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready,
  output sgam_pkg::gain_bank_t              gains
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sgam_pkg::NUM_GAIN_REGS; i++) begin
        gains[i] <= sgam_pkg::GAIN_RESET;
      end
    end else if (wr_en) begin
      gains[paddr[sgam_pkg::CFG_AW-1:2]] <= pwdata[sgam_pkg::GAIN_W-1:0];
    end
  end

  assign prdata = {{(sgam_pkg::CFG_DW - sgam_pkg::GAIN_W){1'b0}},
                   gains[paddr[sgam_pkg::CFG_AW-1:2]]};

endmodule

// ===== rtl/core/sgam_acc_ram.sv =====
`timescale 1ns / 1ps

module sgam_acc_ram #(
  parameter int DEPTH = 960,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [sgam_pkg::ACC_W-1:0]  rdata,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [sgam_pkg::ACC_W-1:0]  wdata
);

  logic [sgam_pkg::ACC_W-1:0] mem [DEPTH];

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sgam_pcm_sat.sv =====
`timescale 1ns / 1ps

module sgam_pcm_sat (
  input  logic                                clk,
  input  logic                                rst,
  input  sgam_pkg::acc_beat_t                 beat,
  output logic                                result_valid,
  output logic signed [sgam_pkg::SAMPLE_W-1:0] mixed_sample,
  output logic [sgam_pkg::POS_W-1:0]          out_position
);

  localparam int FW = sgam_pkg::PCM_FLOOR_W;

  logic [FW-1:0]                 floor_val;
  logic [FW-1:0]                 trunc_val;
  logic                          round_up;
  logic [sgam_pkg::SAMPLE_W-1:0] pcm;

  // floor shift, then step toward zero for negative values with a fraction, then clamp to int16
  always_comb begin
    floor_val = beat.sum[sgam_pkg::ACC_W-1:16];
    round_up  = beat.sum[sgam_pkg::ACC_W-1] && (|beat.sum[15:0]);
    trunc_val = floor_val + {{(FW - 1){1'b0}}, round_up};
    if (trunc_val[FW-1:sgam_pkg::SAMPLE_W-1] == '0 ||
        trunc_val[FW-1:sgam_pkg::SAMPLE_W-1] == '1) begin
      pcm = trunc_val[sgam_pkg::SAMPLE_W-1:0];
    end else if (trunc_val[FW-1]) begin
      pcm = {1'b1, {(sgam_pkg::SAMPLE_W - 1){1'b0}}};
    end else begin
      pcm = {1'b0, {(sgam_pkg::SAMPLE_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    mixed_sample <= pcm;
    out_position <= beat.pos;
  end

endmodule

// ===== rtl/core/saturating_gain_audio_mixer_top.sv =====
`timescale 1ns / 1ps

// saturating gain audio mixer
// input channel: a sample beat (source_index, sample_position, sample,
//   has_data, last_source) is taken at a clock edge with start high and
//   busy low; one beat can be taken every cycle
// each beat is scaled by its source gain (unsigned Q8.16) and summed into a
//   42-bit accumulator entry for its frame position, unless the source is
//   silent, muted or out of range; positions at or beyond FRAME_LEN are dropped
// a beat with last_source set emits the truncated, int16-saturated sum of its
//   position and clears that entry
// output channel: result_valid is high for exactly one cycle with
//   mixed_sample and out_position; the receiver cannot stall, so results are
//   never held off and the input side never waits on the output side
// result path: an accepted beat passes the stage 1 registers, the stage 2
//   register and the output register of the converter
// throughput: 1 beat per cycle while busy is low, set by the single read and single write port
//   of the accumulator ram; a back-to-back beat to the same position gets the
//   freshly written sum through a one-entry forward path
// reset: gains return to unity, then a clearing pass writes zero to every
//   accumulator entry with busy high; the apb port takes gain writes during
//   that pass
// config: apb, gain_i at byte address 4*i, pready always high

module saturating_gain_audio_mixer_top #(
  parameter int FRAME_LEN   = 960,
  parameter int NUM_SOURCES = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [sgam_pkg::SRC_W-1:0]           source_index,
  input  logic [sgam_pkg::POS_W-1:0]           sample_position,
  input  logic signed [sgam_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 has_data,
  input  logic                                 last_source,
  // result channel
  output logic                                 result_valid,
  output logic signed [sgam_pkg::SAMPLE_W-1:0] mixed_sample,
  output logic [sgam_pkg::POS_W-1:0]           out_position,
  // config port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sgam_pkg::CFG_AW-1:0]          paddr,
  input  logic [sgam_pkg::CFG_DW-1:0]          pwdata,
  output logic [sgam_pkg::CFG_DW-1:0]          prdata,
  output logic                                 pready
);

  localparam int AW = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

  sgam_pkg::gain_bank_t gains;

  // intake
  logic                                accept;
  logic [sgam_pkg::POS_EXT_W-1:0]      pos_ext;
  logic                                in_range;
  logic                                src_ok;
  sgam_pkg::gain_t                     gain_sel;
  logic                                contrib;

  // clearing pass
  logic                                clr_active;
  logic [AW-1:0]                       clr_idx;

  // read-modify-write stage
  logic                                s1_valid;
  logic [sgam_pkg::POS_W-1:0]          s1_pos;
  logic [AW-1:0]                       s1_addr;
  logic                                s1_last;
  logic                                s1_add;
  logic signed [sgam_pkg::PROD_W-1:0]  s1_prod;
  logic                                fwd_hit;
  logic [sgam_pkg::ACC_W-1:0]          fwd_data;
  logic [sgam_pkg::ACC_W-1:0]          rd_data;
  logic [sgam_pkg::ACC_W-1:0]          base;
  logic [sgam_pkg::ACC_W-1:0]          sum;
  logic [sgam_pkg::ACC_W-1:0]          wr_value;

  // ram write port
  logic                                ram_we;
  logic [AW-1:0]                       ram_waddr;
  logic [sgam_pkg::ACC_W-1:0]          ram_wdata;

  sgam_pkg::acc_beat_t                 s2;

  sgam_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  // busy only while the accumulator is being cleared
  assign busy   = clr_active;
  assign accept = start && !busy;

  assign pos_ext  = {{(sgam_pkg::POS_EXT_W - sgam_pkg::POS_W){1'b0}}, sample_position};
  assign in_range = pos_ext < sgam_pkg::POS_EXT_W'(FRAME_LEN);
  assign src_ok   = {{(sgam_pkg::SRC_CMP_W - sgam_pkg::SRC_W){1'b0}}, source_index} <
                    sgam_pkg::SRC_CMP_W'(NUM_SOURCES);
  assign gain_sel = gains[source_index];
  // silent, muted or unknown sources add nothing
  assign contrib  = has_data && (gain_sel != '0) && src_ok;

  // clearing pass after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      if (clr_idx == AW'(FRAME_LEN - 1)) begin
        clr_active <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && in_range;
    end
  end

  // stage 1 payload: product registered ahead of the add
  always_ff @(posedge clk) begin
    s1_pos   <= sample_position;
    s1_addr  <= pos_ext[AW-1:0];
    s1_last  <= last_source;
    s1_add   <= contrib;
    s1_prod  <= sample * $signed({1'b0, gain_sel});
    // the entry written at this edge is not yet visible at the ram read port
    fwd_hit  <= s1_valid && (s1_addr == pos_ext[AW-1:0]);
    fwd_data <= wr_value;
  end

  sgam_acc_ram #(
    .DEPTH (FRAME_LEN),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .re    (accept && in_range),
    .raddr (pos_ext[AW-1:0]),
    .rdata (rd_data),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata)
  );

  // modify: add the scaled sample, clear the entry on the frame's last source
  always_comb begin
    base     = fwd_hit ? fwd_data : rd_data;
    sum      = base + (s1_add ? {s1_prod[sgam_pkg::PROD_W-1], s1_prod} : '0);
    wr_value = s1_last ? '0 : sum;
  end

  assign ram_we    = clr_active || s1_valid;
  assign ram_waddr = clr_active ? clr_idx : s1_addr;
  assign ram_wdata = clr_active ? '0 : wr_value;

  // stage 2: sum waiting for conversion
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1_valid && s1_last;
    end
    s2.pos <= s1_pos;
    s2.sum <= sum;
  end

  sgam_pcm_sat u_pcm (
    .clk          (clk),
    .rst          (rst),
    .beat         (s2),
    .result_valid (result_valid),
    .mixed_sample (mixed_sample),
    .out_position (out_position)
  );

endmodule

// ===== rtl/core/sgam_checker.sv =====
`timescale 1ns / 1ps

module sgam_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic [sgam_pkg::POS_W-1:0]           sample_position,
  input logic                                 last_source,
  input logic                                 result_valid,
  input logic [sgam_pkg::POS_W-1:0]           out_position
);

  // reset starts the clearing pass
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy not raised after reset");

  // once the clearing pass is over, busy stays low
  a_busy_no_rise: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("busy raised outside reset");

  // no result while the accumulator is still being cleared
  a_no_result_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !result_valid)
    else $error("result during clearing pass");

  // every result comes from an accepted last-source beat at the same position
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(start && !busy && last_source, 3) &&
                      out_position == $past(sample_position, 3)))
    else $error("result without matching last-source beat");

endmodule

bind saturating_gain_audio_mixer_top sgam_checker u_sgam_checker (.*);

// ===== tb/sv/sgam_mix_checker.sv =====
`timescale 1ns / 1ps

module sgam_mix_checker #(
  parameter int FRAME_LEN   = 960,
  parameter int NUM_SOURCES = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [sgam_pkg::SRC_W-1:0]           source_index,
  input  logic [sgam_pkg::POS_W-1:0]           sample_position,
  input  logic signed [sgam_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 has_data,
  input  logic                                 last_source,
  input  logic                                 result_valid,
  input  logic signed [sgam_pkg::SAMPLE_W-1:0] mixed_sample,
  input  logic [sgam_pkg::POS_W-1:0]           out_position,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sgam_pkg::CFG_AW-1:0]          paddr,
  input  logic [sgam_pkg::CFG_DW-1:0]          pwdata,
  input  logic [sgam_pkg::CFG_DW-1:0]          prdata,
  input  logic                                 pready,
  output int                                   mismatches,
  output int                                   outstanding
);

  localparam longint PCM_MAX    = 32767;
  localparam longint PCM_MIN    = -32768;
  localparam int     FRAC_BITS  = 16;
  localparam int     REPORT_MAX = 10;

  typedef struct packed {
    logic signed [sgam_pkg::SAMPLE_W-1:0] pcm;
    logic [sgam_pkg::POS_W-1:0]           pos;
  } mixed_t;

  sgam_pkg::gain_t            gain_copy [sgam_pkg::NUM_GAIN_REGS];
  logic [sgam_pkg::ACC_W-1:0] acc_sum [FRAME_LEN];
  mixed_t                     expected_mix [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void flag(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch @%0t: %s", $time, what);
  endfunction

  // scale, accumulate, and on the last source emit and clear the entry
  function automatic void mix_beat(input logic [sgam_pkg::SRC_W-1:0] src,
                                   input logic [sgam_pkg::POS_W-1:0] pos,
                                   input logic signed [sgam_pkg::SAMPLE_W-1:0] pcm,
                                   input logic live, input logic last);
    longint prod;
    longint total;
    longint whole;
    mixed_t got;
    if (pos >= FRAME_LEN)
      return;
    if (live && gain_copy[src] != '0 && src < NUM_SOURCES) begin
      prod = longint'(pcm) * longint'(gain_copy[src]);
      acc_sum[pos] = acc_sum[pos] + sgam_pkg::ACC_W'(prod);
    end
    if (!last)
      return;
    total = longint'($signed(acc_sum[pos]));
    // truncate toward zero, then clamp to int16
    whole = (total >= 0) ? (total >>> FRAC_BITS) : -((-total) >>> FRAC_BITS);
    if (whole > PCM_MAX)
      whole = PCM_MAX;
    if (whole < PCM_MIN)
      whole = PCM_MIN;
    got.pcm = whole[sgam_pkg::SAMPLE_W-1:0];
    got.pos = pos;
    expected_mix = {expected_mix, got};
    acc_sum[pos] = '0;
  endfunction

  always @(posedge clk) begin
    mixed_t want;
    int     idx;
    if (rst) begin
      for (int i = 0; i < sgam_pkg::NUM_GAIN_REGS; i++)
        gain_copy[i] = sgam_pkg::GAIN_RESET;
      for (int i = 0; i < FRAME_LEN; i++)
        acc_sum[i] = '0;
      expected_mix.delete();
    end else begin
      // results first: a beat taken at this edge cannot have its result yet
      if (result_valid) begin
        if (expected_mix.size() == 0) begin
          flag($sformatf("unexpected result pos %0d sample %0d", out_position, mixed_sample));
        end else begin
          want = expected_mix.pop_front();
          if (mixed_sample !== want.pcm || out_position !== want.pos)
            flag($sformatf("pos exp %0d got %0d, sample exp %0d got %0d",
                           want.pos, out_position, $signed(want.pcm), mixed_sample));
        end
      end
      if (start && !busy)
        mix_beat(source_index, sample_position, sample, has_data, last_source);
      if (psel && penable && pready) begin
        idx = int'(paddr >> 2);
        if (pwrite) begin
          if (idx < sgam_pkg::NUM_GAIN_REGS)
            gain_copy[idx] = pwdata[sgam_pkg::GAIN_W-1:0];
        end else if (idx < sgam_pkg::NUM_GAIN_REGS) begin
          if (prdata !== sgam_pkg::CFG_DW'(gain_copy[idx]))
            flag($sformatf("gain_%0d read exp %0h got %0h", idx, gain_copy[idx], prdata));
        end
      end
    end
    outstanding = expected_mix.size();
  end

endmodule

// ===== tb/sv/tb_saturating_gain_audio_mixer_top.sv =====
`timescale 1ns / 1ps

module tb_saturating_gain_audio_mixer_top;

  localparam int FRAME_LEN     = 960;
  localparam int NUM_SOURCES   = 4;
  localparam int GAIN_STRIDE   = 4;     // byte stride of the gain registers
  localparam int STALL_LIMIT   = 5000;  // covers the clearing pass after reset
  localparam int SETTLE_CYCLES = 10;    // margin past the result latency
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_BEATS   = 190;
  localparam int HOT_SPAN      = 8;     // small position pool for reuse

  // roles of the sources in the directed part, set by the gains loaded there
  localparam logic [sgam_pkg::SRC_W-1:0] SRC_MUTED = 2'd0;
  localparam logic [sgam_pkg::SRC_W-1:0] SRC_FULL  = 2'd1;
  localparam logic [sgam_pkg::SRC_W-1:0] SRC_TINY  = 2'd2;
  localparam logic [sgam_pkg::SRC_W-1:0] SRC_UNITY = 2'd3;

  localparam sgam_pkg::gain_t GAIN_OFF  = 24'd0;
  localparam sgam_pkg::gain_t GAIN_LSB  = 24'd1;
  localparam sgam_pkg::gain_t GAIN_FULL = 24'hFFFFFF;

  localparam logic signed [sgam_pkg::SAMPLE_W-1:0] PCM_TOP = 16'sh7FFF;
  localparam logic signed [sgam_pkg::SAMPLE_W-1:0] PCM_BOT = 16'sh8000;

  typedef enum int {
    GAINS_UNITY,
    GAINS_RANDOM,
    GAINS_FULL,
    GAINS_SMALL,
    GAINS_MUTED,
    GAINS_MIXED
  } gain_mode_e;

  // per phase: how the gains are chosen and how often the sender idles
  gain_mode_e phase_gains [NUM_PHASES] = '{GAINS_UNITY, GAINS_RANDOM, GAINS_FULL,
                                           GAINS_SMALL, GAINS_MUTED, GAINS_MIXED};
  int         phase_idle  [NUM_PHASES] = '{0, 51, 11, 0, 51, 11};

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 start;
  logic                                 busy;
  logic [sgam_pkg::SRC_W-1:0]           source_index;
  logic [sgam_pkg::POS_W-1:0]           sample_position;
  logic signed [sgam_pkg::SAMPLE_W-1:0] sample;
  logic                                 has_data;
  logic                                 last_source;
  logic                                 result_valid;
  logic signed [sgam_pkg::SAMPLE_W-1:0] mixed_sample;
  logic [sgam_pkg::POS_W-1:0]           out_position;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [sgam_pkg::CFG_AW-1:0]          paddr;
  logic [sgam_pkg::CFG_DW-1:0]          pwdata;
  logic [sgam_pkg::CFG_DW-1:0]          prdata;
  logic                                 pready;

  int              mismatches;
  int              outstanding;
  int              idle_pct;     // chance in percent that the sender idles a cycle
  int              beats_sent;   // beats at positions the block actually uses
  int              stall_cycles;
  sgam_pkg::gain_t gain_plan [sgam_pkg::NUM_GAIN_REGS];

  saturating_gain_audio_mixer_top #(
    .FRAME_LEN   (FRAME_LEN),
    .NUM_SOURCES (NUM_SOURCES)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .source_index    (source_index),
    .sample_position (sample_position),
    .sample          (sample),
    .has_data        (has_data),
    .last_source     (last_source),
    .result_valid    (result_valid),
    .mixed_sample    (mixed_sample),
    .out_position    (out_position),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // watches both channels and the config port, predicts and compares
  sgam_mix_checker #(
    .FRAME_LEN   (FRAME_LEN),
    .NUM_SOURCES (NUM_SOURCES)
  ) mix_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .source_index    (source_index),
    .sample_position (sample_position),
    .sample          (sample),
    .has_data        (has_data),
    .last_source     (last_source),
    .result_valid    (result_valid),
    .mixed_sample    (mixed_sample),
    .out_position    (out_position),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always #1 clk = ~clk;

  // watchdog: cycles in which neither a sample beat nor a result went through
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || result_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one apb transfer: setup cycle, access cycle, then the bus goes idle
  task automatic reg_access(input logic write, input int index,
                            input logic [sgam_pkg::CFG_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= sgam_pkg::CFG_AW'(index * GAIN_STRIDE);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // sender holds off, waits until every expected result is back, then lets
  // the pipe run dry
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write gain_plan into the block (junk in the unused upper byte), read it back
  task automatic load_gains;
    drain();
    for (int i = 0; i < sgam_pkg::NUM_GAIN_REGS; i++)
      reg_access(1'b1, i, {8'($urandom), gain_plan[i]});
    for (int i = 0; i < sgam_pkg::NUM_GAIN_REGS; i++)
      reg_access(1'b0, i, '0);
  endtask

  function automatic sgam_pkg::gain_t pick_gain(input gain_mode_e mode);
    case (mode)
      GAINS_UNITY:  return sgam_pkg::GAIN_RESET;
      GAINS_RANDOM: return sgam_pkg::GAIN_W'($urandom);
      GAINS_FULL:   return GAIN_FULL;
      GAINS_SMALL:  return ($urandom_range(3) == 0) ? GAIN_OFF
                                                    : sgam_pkg::GAIN_W'($urandom_range(131071));
      GAINS_MUTED:  return GAIN_OFF;
      default: begin
        case ($urandom_range(4))
          0:       return GAIN_OFF;
          1:       return GAIN_LSB;
          2:       return sgam_pkg::GAIN_RESET;
          3:       return GAIN_FULL;
          default: return sgam_pkg::GAIN_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // samples lean toward the rails and the values around zero
  function automatic logic signed [sgam_pkg::SAMPLE_W-1:0] pick_sample;
    case ($urandom_range(9))
      0:       return PCM_BOT;
      1:       return PCM_TOP;
      2:       return '0;
      3:       return -16'sd1;
      4:       return 16'sd1;
      default: return sgam_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // present one beat, idling first at the phase rate; junk rides the idle cycles
  task automatic send_beat(input logic [sgam_pkg::SRC_W-1:0] src,
                           input logic [sgam_pkg::POS_W-1:0] pos,
                           input logic signed [sgam_pkg::SAMPLE_W-1:0] pcm,
                           input logic live, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start           <= 1'b0;
      source_index    <= sgam_pkg::SRC_W'($urandom);
      sample_position <= sgam_pkg::POS_W'($urandom);
      sample          <= sgam_pkg::SAMPLE_W'($urandom);
      has_data        <= 1'($urandom);
      last_source     <= 1'($urandom);
    end
    @(negedge clk);
    start           <= 1'b1;
    source_index    <= src;
    sample_position <= pos;
    sample          <= pcm;
    has_data        <= live;
    last_source     <= last;
    do @(posedge clk); while (busy);
    if (pos < FRAME_LEN)
      beats_sent++;
  endtask

  // random traffic: mostly whole frames at a position, some noise, some partial frames
  task automatic run_traffic(input int quota);
    int goal;
    int kind;
    int pos;
    int count;
    int first;
    goal = beats_sent + quota;
    while (beats_sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        // well-formed frame: distinct sources, the final one closes the entry
        pos   = ($urandom_range(99) < 30) ? $urandom_range(HOT_SPAN - 1)
                                          : $urandom_range(FRAME_LEN - 1);
        count = $urandom_range(1, NUM_SOURCES);
        first = $urandom_range(NUM_SOURCES - 1);
        for (int k = 0; k < count; k++)
          send_beat(sgam_pkg::SRC_W'((first + k) % NUM_SOURCES), sgam_pkg::POS_W'(pos),
                    pick_sample(), $urandom_range(99) < 85, k == count - 1);
      end else if (kind < 90) begin
        // noise over the whole field space, positions past the frame included
        send_beat(sgam_pkg::SRC_W'($urandom), sgam_pkg::POS_W'($urandom),
                  sgam_pkg::SAMPLE_W'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        // broken frame: contributions without a closing beat, picked up later
        pos   = $urandom_range(HOT_SPAN - 1);
        count = $urandom_range(1, NUM_SOURCES);
        for (int k = 0; k < count; k++)
          send_beat(sgam_pkg::SRC_W'($urandom), sgam_pkg::POS_W'(pos), pick_sample(),
                    1'b1, 1'b0);
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    source_index    = '0;
    sample_position = '0;
    sample          = '0;
    has_data        = 1'b0;
    last_source     = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    idle_pct        = 0;
    beats_sent      = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part: one muted, one full-scale, one lsb and one unity source
    gain_plan[SRC_MUTED] = GAIN_OFF;
    gain_plan[SRC_FULL]  = GAIN_FULL;
    gain_plan[SRC_TINY]  = GAIN_LSB;
    gain_plan[SRC_UNITY] = sgam_pkg::GAIN_RESET;
    load_gains();

    // rails at unity, first and last frame positions
    send_beat(SRC_UNITY, 10'd0, PCM_TOP, 1'b1, 1'b1);
    send_beat(SRC_UNITY, 10'd959, PCM_BOT, 1'b1, 1'b1);
    // positive and negative saturation
    send_beat(SRC_FULL, 10'd1, PCM_TOP, 1'b1, 1'b0);
    send_beat(SRC_UNITY, 10'd1, 16'sd1, 1'b1, 1'b1);
    send_beat(SRC_FULL, 10'd2, PCM_BOT, 1'b1, 1'b1);
    // muted source, then a silent closing source: nothing contributes
    send_beat(SRC_MUTED, 10'd3, 16'sd12345, 1'b1, 1'b0);
    send_beat(SRC_UNITY, 10'd3, 16'sd100, 1'b0, 1'b1);
    // fractions of a negative sum truncate toward zero
    send_beat(SRC_TINY, 10'd4, -16'sd1, 1'b1, 1'b1);
    send_beat(SRC_UNITY, 10'd6, -16'sd5, 1'b1, 1'b0);
    send_beat(SRC_TINY, 10'd6, PCM_BOT, 1'b1, 1'b1);
    // positions past the frame are dropped even when closing
    send_beat(SRC_UNITY, 10'd1023, 16'sd777, 1'b1, 1'b1);
    send_beat(SRC_UNITY, 10'd960, 16'sd777, 1'b1, 1'b1);
    // accumulator wraps after enough full-scale contributions
    for (int k = 0; k < 6; k++)
      send_beat(SRC_FULL, 10'd7, PCM_BOT, 1'b1, 1'b0);
    send_beat(SRC_UNITY, 10'd7, 16'sd0, 1'b0, 1'b1);
    // back-to-back beats to one position go through the forward path
    send_beat(SRC_UNITY, 10'd8, 16'sd100, 1'b1, 1'b0);
    send_beat(SRC_UNITY, 10'd8, 16'sd200, 1'b1, 1'b0);
    send_beat(SRC_UNITY, 10'd8, 16'sd300, 1'b1, 1'b1);
    // every source into one position
    send_beat(SRC_MUTED, 10'd9, 16'sd1000, 1'b1, 1'b0);
    send_beat(SRC_FULL, 10'd9, 16'sd1, 1'b1, 1'b0);
    send_beat(SRC_TINY, 10'd9, 16'sd30000, 1'b1, 1'b0);
    send_beat(SRC_UNITY, 10'd9, -16'sd100, 1'b1, 1'b1);

    // random phases, each with its own gains and sender idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < sgam_pkg::NUM_GAIN_REGS; i++)
        gain_plan[i] = pick_gain(phase_gains[p]);
      load_gains();
      idle_pct = phase_idle[p];
      run_traffic(PHASE_BEATS / 2);
      // sender holds off mid-phase until every result is home
      @(negedge clk);
      start <= 1'b0;
      drain();
      run_traffic(PHASE_BEATS - PHASE_BEATS / 2);
    end

    @(negedge clk);
    start <= 1'b0;
    drain();

    if (mismatches == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
